// ----- rtl/core/fswt_pkg.sv -----
// ----------------------------------------------------------------------------
// Framed serial word transmitter package
// Shared command type, sequencer states, framing constants and the word
// framing function.
// ----------------------------------------------------------------------------
`default_nettype none

package fswt_pkg;

  typedef enum logic {
    OP_TICK,
    OP_BYTE
  } op_t;

  typedef enum logic [1:0] {
    BK_READY,
    BK_PUSH_BYTE,
    BK_PUSH_END
  } bk_state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } cmd_t;

  localparam logic [7:0]  START_BYTE = 8'h00;
  localparam logic [7:0]  END_BYTE   = 8'hAA;
  localparam logic [15:0] EMPTY_WORD = 16'hFFFF;
  localparam logic [3:0]  WORD_TOP   = 4'hF;
  localparam logic [4:0]  LAST_BIT   = 5'd15;

  // Start bit 0, data bits, parity bit and two stop bits; the low 12 bits.
  function automatic logic [11:0] frame_word(input logic [7:0] data, input logic odd);
    logic par;
    par = (^data) ^ odd;
    return {2'b11, par, data, 1'b0};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fswt_front.sv -----
// ----------------------------------------------------------------------------
// Framed serial word transmitter front end
// Accepts requests, classifies them into tick or byte commands and holds
// them in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fswt_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_mode,
  input  wire logic [7:0]    in_byte_value,
  input  wire logic          in_first_byte,
  input  wire logic          in_last_byte,
  output logic               cmd_valid,
  output fswt_pkg::cmd_t     cmd,
  input  wire logic          cmd_ready
);
  import fswt_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  cmd_t       cmd_in;
  logic       push;
  logic       pop;

  always_comb begin
    cmd_in.op         = in_mode ? OP_BYTE : OP_TICK;
    cmd_in.byte_value = in_mode ? in_byte_value : 8'd0;
    cmd_in.first_byte = in_mode & in_first_byte;
    cmd_in.last_byte  = in_mode & in_last_byte;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = ent_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fswt_back.sv -----
// ----------------------------------------------------------------------------
// Framed serial word transmitter back end
// Executes commands: frames and stores words in the word memory, drives the
// serial clock and data lines on ticks and registers one result per command.
// ----------------------------------------------------------------------------
`default_nettype none

module fswt_back #(
  parameter int QUEUE_DEPTH = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire fswt_pkg::cmd_t cmd,
  output logic               cmd_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_clock_level,
  output logic               out_data_level,
  output logic [1:0]         out_words_dropped,
  output logic [8:0]         out_queue_level
);
  import fswt_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [11:0]   mem [QUEUE_DEPTH];
  logic [11:0]   rd_q_r;

  bk_state_t     state_r;
  bk_state_t     state_nxt;
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          phase_r;
  logic          phase_nxt;
  logic [4:0]    bitpos_r;
  logic [4:0]    bitpos_nxt;
  logic [15:0]   cur_word_r;
  logic          from_mem_r;
  logic          data_r;
  logic          data_nxt;
  logic [1:0]    drop_r;
  logic [1:0]    drop_sum;

  logic          out_valid_r;
  logic          out_clock_r;
  logic          out_data_r;
  logic [1:0]    out_drop_r;
  logic [8:0]    out_level_r;

  logic          out_free;
  logic          step;
  logic          do_push;
  logic          do_tick;
  logic          done;
  logic [11:0]   push_word;
  logic          full;
  logic          empty;
  logic          wr_en;
  logic          drop_now;
  logic          pop;
  logic          rd_en;
  logic [15:0]   cur_word;
  logic [CW+8:0] level_ext;

  assign out_free = !out_valid_r || out_ready;
  assign step     = cmd_valid && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_READY: begin
        if (step && cmd.op == OP_BYTE) begin
          if (cmd.first_byte) begin
            state_nxt = BK_PUSH_BYTE;
          end else if (cmd.last_byte) begin
            state_nxt = BK_PUSH_END;
          end
        end
      end
      BK_PUSH_BYTE: begin
        if (step) begin
          state_nxt = cmd.last_byte ? BK_PUSH_END : BK_READY;
        end
      end
      BK_PUSH_END: begin
        if (step) begin
          state_nxt = BK_READY;
        end
      end
      default: state_nxt = BK_READY;
    endcase
  end

  always_comb begin
    do_push   = 1'b0;
    do_tick   = 1'b0;
    done      = 1'b0;
    push_word = frame_word(cmd.byte_value, 1'b1);
    case (state_r)
      BK_READY: begin
        if (step) begin
          if (cmd.op == OP_TICK) begin
            do_tick = 1'b1;
            done    = 1'b1;
          end else begin
            do_push = 1'b1;
            if (cmd.first_byte) begin
              push_word = frame_word(START_BYTE, 1'b0);
            end
            done = !cmd.first_byte && !cmd.last_byte;
          end
        end
      end
      BK_PUSH_BYTE: begin
        if (step) begin
          do_push = 1'b1;
          done    = !cmd.last_byte;
        end
      end
      BK_PUSH_END: begin
        if (step) begin
          do_push   = 1'b1;
          push_word = frame_word(END_BYTE, 1'b0);
          done      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign cmd_ready = done;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign wr_en    = do_push && !full;
  assign drop_now = do_push && full;
  assign pop      = do_tick && phase_r && (bitpos_r > LAST_BIT);
  assign rd_en    = pop && !empty;
  assign drop_sum = drop_r + {1'b0, drop_now};
  assign cur_word = from_mem_r ? {WORD_TOP, rd_q_r} : cur_word_r;

  always_comb begin
    count_nxt = count_r;
    if (wr_en) begin
      count_nxt = count_r + CW'(1);
    end else if (rd_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    data_nxt   = data_r;
    bitpos_nxt = bitpos_r;
    if (do_tick) begin
      phase_nxt = ~phase_r;
      if (!phase_r) begin
        data_nxt   = cur_word[bitpos_r[3:0]];
        bitpos_nxt = bitpos_r + 5'd1;
      end else if (pop) begin
        bitpos_nxt = 5'd0;
      end
    end
  end

  assign level_ext = {9'd0, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_READY;
      wp_r        <= '0;
      rp_r        <= '0;
      count_r     <= '0;
      phase_r     <= 1'b0;
      bitpos_r    <= 5'd0;
      cur_word_r  <= 16'd0;
      from_mem_r  <= 1'b0;
      data_r      <= 1'b0;
      drop_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      phase_r  <= phase_nxt;
      bitpos_r <= bitpos_nxt;
      data_r   <= data_nxt;
      if (wr_en) begin
        wp_r <= (wp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (pop) begin
        if (empty) begin
          cur_word_r <= EMPTY_WORD;
          from_mem_r <= 1'b0;
        end else begin
          from_mem_r <= 1'b1;
        end
      end
      if (done) begin
        drop_r <= 2'd0;
      end else if (do_push) begin
        drop_r <= drop_sum;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_clock_r <= phase_nxt;
      out_data_r  <= data_nxt;
      out_drop_r  <= drop_sum;
      out_level_r <= level_ext[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= push_word;
    end
    if (rd_en) begin
      rd_q_r <= mem[rp_r];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_clock_level   = out_clock_r;
  assign out_data_level    = out_data_r;
  assign out_words_dropped = out_drop_r;
  assign out_queue_level   = out_level_r;

endmodule

`default_nettype wire

// ----- rtl/core/framed_serial_word_transmitter.sv -----
// ----------------------------------------------------------------------------
// Framed serial word transmitter
// The input channel takes one request per item: a timer tick (mode 0) or a
// message byte (mode 1) with first and last markers. A byte is framed into
// 12-bit words (start word, byte word, end word as marked) that wait in a
// word memory of QUEUE_DEPTH entries. Ticks toggle the serial clock; each
// high phase shifts the next word bit onto the data line, and after 16 bits
// the next word is taken from the memory, or all ones when it is empty.
// Every request gives exactly one result on the output channel with the
// line levels, the words dropped on a full memory and the fill level.
// The back end pushes a byte's framed words (one to three) one at a time,
// as the word memory has a single write port. Each result is registered
// in the output register when the back end retires its command.
// A two-entry command queue and an output register let requests keep
// arriving while a result waits. When the receiver stalls, the back end
// holds, then the command queue fills and in_ready falls. Reset empties
// the word memory by clearing its pointers and count; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_serial_word_transmitter #(
  parameter int QUEUE_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_mode,
  input  wire logic [7:0] in_byte_value,
  input  wire logic       in_first_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_clock_level,
  output logic            out_data_level,
  output logic [1:0]      out_words_dropped,
  output logic [8:0]      out_queue_level
);
  import fswt_pkg::*;

  localparam logic [8:0] LEVEL_FULL = 9'(QUEUE_DEPTH % 512);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  fswt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_byte_value (in_byte_value),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_ready     (cmd_ready)
  );

  fswt_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_ready         (cmd_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_clock_level   (out_clock_level),
    .out_data_level    (out_data_level),
    .out_words_dropped (out_words_dropped),
    .out_queue_level   (out_queue_level)
  );

  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_ready |-> cmd_valid)
    else $error("Back end retired a command that was not there.");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_words_dropped != 2'd0) |-> out_queue_level == LEVEL_FULL)
    else $error("Words were dropped while the word memory was not full.");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

`default_nettype wire

// ----- bench/tb_framed_serial_word_transmitter.sv -----
// ----------------------------------------------------------------------------
// Framed serial word transmitter testbench
// Sends timer ticks and message bytes through the request channel: a short
// table of directed requests first, then random traffic that drains the
// word queue to empty, fills it past full and keeps it near full. Every
// result is compared field by field to typed table rows or to a behavioral
// model in step with accepted requests. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_framed_serial_word_transmitter;
  import fswt_pkg::*;

  localparam int DEPTH     = 256;
  localparam int RAND_REQS = 1200;
  localparam int DIR_ROWS  = 20;

  typedef struct packed {
    logic       clock_level;
    logic       data_level;
    logic [1:0] words_dropped;
    logic [8:0] queue_level;
  } line_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
    logic       first;
    logic       last;
    logic       typed;
    line_t      want;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_mode;
  logic [7:0] in_byte_value;
  logic       in_first_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_clock_level;
  logic       out_data_level;
  logic [1:0] out_words_dropped;
  logic [8:0] out_queue_level;

  logic [11:0] word_mem [DEPTH];
  int unsigned mem_rd;
  int unsigned mem_wr;
  int unsigned mem_count;
  logic        clk_phase;
  logic [4:0]  bit_pos;
  logic [15:0] shift_word;
  logic        data_bit;

  line_t    expected_lines[$];
  dir_row_t dir_rows [DIR_ROWS];
  int       errors;
  int       accepted;
  int       n_ticks;
  int       n_bytes;
  int       n_dropped;
  int       n_empty_pops;
  int       n_results;
  int       peak_level;
  bit       calm;
  bit       hold_a_done;
  bit       hold_b_done;

  framed_serial_word_transmitter #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_byte_value    (in_byte_value),
    .in_first_byte    (in_first_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_clock_level  (out_clock_level),
    .out_data_level   (out_data_level),
    .out_words_dropped(out_words_dropped),
    .out_queue_level  (out_queue_level)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [11:0] build_word(logic [7:0] value, logic odd);
    return {2'b11, (^value) ^ odd, value, 1'b0};
  endfunction

  function automatic logic [1:0] store_word(logic [11:0] word);
    if (mem_count >= DEPTH) begin
      return 2'd1;
    end
    word_mem[mem_wr] = word;
    mem_wr = (mem_wr + 1) % DEPTH;
    mem_count++;
    return 2'd0;
  endfunction

  function automatic logic [15:0] fetch_word();
    logic [11:0] word;
    if (mem_count == 0) begin
      n_empty_pops++;
      return EMPTY_WORD;
    end
    word = word_mem[mem_rd];
    mem_rd = (mem_rd + 1) % DEPTH;
    mem_count--;
    return {WORD_TOP, word};
  endfunction

  function automatic line_t transmit_step(op_t op, logic [7:0] value, logic first,
                                          logic last);
    logic [1:0] drops;
    line_t      res;
    drops = 2'd0;
    if (op == OP_BYTE) begin
      if (first) begin
        drops += store_word(build_word(START_BYTE, 1'b0));
      end
      drops += store_word(build_word(value, 1'b1));
      if (last) begin
        drops += store_word(build_word(END_BYTE, 1'b0));
      end
    end else if (!clk_phase) begin
      clk_phase = 1'b1;
      data_bit  = shift_word[bit_pos[3:0]];
      bit_pos   = bit_pos + 5'd1;
    end else begin
      clk_phase = 1'b0;
      if (bit_pos > LAST_BIT) begin
        bit_pos    = 5'd0;
        shift_word = fetch_word();
      end
    end
    res.clock_level   = clk_phase;
    res.data_level    = data_bit;
    res.words_dropped = drops;
    res.queue_level   = mem_count[8:0];
    return res;
  endfunction

  task automatic send_request(op_t op, logic [7:0] value, logic first, logic last,
                              logic typed, line_t want);
    int    gap;
    int    pick;
    line_t model;
    gap = 0;
    if (!calm) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        gap = 0;
      end else if (pick < 92) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(8, 40);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= op;
    in_byte_value <= value;
    in_first_byte <= first;
    in_last_byte  <= last;
    do begin
      @(posedge clk);
    end while (!in_ready);
    model = transmit_step(op, value, first, last);
    expected_lines.push_back(typed ? want : model);
    accepted++;
    if (op == OP_BYTE) begin
      n_bytes++;
    end else begin
      n_ticks++;
    end
    @(negedge clk);
  endtask

  task automatic check_line(line_t got);
    line_t want;
    if (expected_lines.size() == 0) begin
      $error("result with no request waiting for it");
      errors++;
      return;
    end
    want = expected_lines.pop_front();
    n_results++;
    if (got.clock_level !== want.clock_level) begin
      $error("clock_level: expected %0d, got %0d", want.clock_level, got.clock_level);
      errors++;
    end
    if (got.data_level !== want.data_level) begin
      $error("data_level: expected %0d, got %0d", want.data_level, got.data_level);
      errors++;
    end
    if (got.words_dropped !== want.words_dropped) begin
      $error("words_dropped: expected %0d, got %0d", want.words_dropped,
             got.words_dropped);
      errors++;
    end
    if (got.queue_level !== want.queue_level) begin
      $error("queue_level: expected %0d, got %0d", want.queue_level, got.queue_level);
      errors++;
    end
    n_dropped += got.words_dropped;
    if (got.queue_level > peak_level) begin
      peak_level = got.queue_level;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_line('{out_clock_level, out_data_level, out_words_dropped, out_queue_level});
    end
  end

  // The two long receiver hold-offs let the command queue fill and stall requests.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_a_done && accepted >= 520) begin
        hold_a_done = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (!hold_b_done && accepted >= 950) begin
        hold_b_done = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        stall = $urandom_range(10, 40);
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    op_t        op;
    logic [7:0] value;
    logic       first;
    logic       last;
    int         chance;

    in_valid      = 1'b0;
    in_mode       = OP_TICK;
    in_byte_value = 8'h00;
    in_first_byte = 1'b0;
    in_last_byte  = 1'b0;
    rst_n         = 1'b0;
    calm          = 1'b1;
    errors        = 0;
    accepted      = 0;
    n_ticks       = 0;
    n_bytes       = 0;
    n_dropped     = 0;
    n_empty_pops  = 0;
    n_results     = 0;
    peak_level    = 0;
    hold_a_done   = 1'b0;
    hold_b_done   = 1'b0;
    mem_rd        = 0;
    mem_wr        = 0;
    mem_count     = 0;
    clk_phase     = 1'b0;
    bit_pos       = 5'd0;
    shift_word    = 16'h0000;
    data_bit      = 1'b0;

    dir_rows = '{
      '{OP_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b0, 2'd0, 9'd0}},
      '{OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 2'd0, 9'd0}},
      '{OP_BYTE, 8'h00, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 2'd0, 9'd3}},
      '{OP_BYTE, 8'hFF, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 2'd0, 9'd4}},
      '{OP_BYTE, 8'h80, 1'b1, 1'b0, 1'b1, '{1'b0, 1'b0, 2'd0, 9'd6}},
      '{OP_BYTE, 8'h01, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, 2'd0, 9'd8}},
      '{OP_TICK, 8'hAA, 1'b1, 1'b0, 1'b0, '0},
      '{OP_TICK, 8'h55, 1'b0, 1'b1, 1'b0, '0},
      '{OP_TICK, 8'h7F, 1'b1, 1'b1, 1'b0, '0},
      '{OP_TICK, 8'hFE, 1'b0, 1'b0, 1'b0, '0},
      '{OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{OP_TICK, 8'hFF, 1'b1, 1'b1, 1'b0, '0},
      '{OP_TICK, 8'h01, 1'b0, 1'b1, 1'b0, '0},
      '{OP_TICK, 8'h80, 1'b1, 1'b0, 1'b0, '0},
      '{OP_TICK, 8'h3C, 1'b0, 1'b0, 1'b0, '0},
      '{OP_TICK, 8'hC3, 1'b1, 1'b1, 1'b0, '0},
      '{OP_TICK, 8'h0F, 1'b0, 1'b0, 1'b0, '0},
      '{OP_TICK, 8'hF0, 1'b0, 1'b1, 1'b0, '0},
      '{OP_TICK, 8'h5A, 1'b1, 1'b0, 1'b0, '0},
      '{OP_TICK, 8'hA5, 1'b0, 1'b0, 1'b0, '0}
    };

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(dir_rows[i].op, dir_rows[i].value, dir_rows[i].first,
                   dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    end

    // Drain to empty first, then flood with bytes, then hold the queue near full.
    for (int i = 0; i < RAND_REQS; i++) begin
      calm   = ((i / 80) % 5 == 0);
      value  = $urandom_range(0, 255);
      first  = $urandom_range(0, 1);
      last   = $urandom_range(0, 1);
      chance = $urandom_range(0, 99);
      if (i < 500) begin
        op = (mem_count < 2 && chance < 4) ? OP_BYTE : OP_TICK;
      end else if (i < 700) begin
        op = (chance < 90) ? OP_BYTE : OP_TICK;
      end else begin
        op = (chance < 25) ? OP_BYTE : OP_TICK;
      end
      send_request(op, value, first, last, 1'b0, '0);
    end

    in_valid <= 1'b0;
    calm = 1'b1;
    while (expected_lines.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    $display("Covered %0d ticks and %0d bytes over %0d checked results.",
             n_ticks, n_bytes, n_results);
    $display("Saw %0d dropped words, %0d empty-queue pops, peak fill %0d.",
             n_dropped, n_empty_pops, peak_level);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
